// File: rtl/msw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msw_pkg: shared types and constants of the Morton deswizzle address unit
// Field widths, configuration register indexes, stage payload structs and
// the bit gather used to split a Morton code into its two axes.
// ----------------------------------------------------------------------------
package msw_pkg;

  localparam int IDX_W      = 30;  // swizzled texel index
  localparam int HALF_W     = 15;  // one axis of the Morton code
  localparam int PIX_W      = 64;  // pixel payload
  localparam int OFF_W      = 33;  // destination byte offset
  localparam int CFG_W      = 4;   // widest configuration register
  localparam int CFG_ADDR_W = 2;   // configuration register index

  localparam int MAX_DIM_LOG2_DEF = 15;

  localparam logic [CFG_W-1:0] BPP_RESET = 4'd4;
  localparam logic [CFG_W-1:0] BPP_MIN   = 4'd1;
  localparam logic [CFG_W-1:0] BPP_MAX   = 4'd8;

  localparam logic [31:0] MASK_1  = 32'h5555_5555;
  localparam logic [31:0] MASK_2  = 32'h3333_3333;
  localparam logic [31:0] MASK_4  = 32'h0f0f_0f0f;
  localparam logic [31:0] MASK_8  = 32'h00ff_00ff;
  localparam logic [31:0] MASK_16 = 32'h0000_ffff;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WIDTH_LOG2  = 2'd0,
    REG_HEIGHT_LOG2 = 2'd1,
    REG_PIXEL_BYTES = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0] source_index;
    logic [PIX_W-1:0] pixel_data;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0] dest_byte_offset;
    logic [PIX_W-1:0] pixel_out;
    logic             in_range;
  } out_t;

  // After the axis split
  typedef struct packed {
    logic [IDX_W-1:0]  hi;
    logic [HALF_W-1:0] xd;
    logic [HALF_W-1:0] yd;
    logic              ok;
    logic [PIX_W-1:0]  pix;
  } unpack_t;

  // After placement in the linear texture, in texels
  typedef struct packed {
    logic [OFF_W-1:0] pos;
    logic             ok;
    logic [PIX_W-1:0] pix;
  } place_t;

  // Gather the even-numbered bits of v into the low half.
  function automatic logic [HALF_W-1:0] even_bits(input logic [31:0] v);
    logic [31:0] t;
    t = v & MASK_1;
    t = (t ^ (t >> 1)) & MASK_2;
    t = (t ^ (t >> 2)) & MASK_4;
    t = (t ^ (t >> 4)) & MASK_8;
    t = (t ^ (t >> 8)) & MASK_16;
    return t[HALF_W-1:0];
  endfunction

endpackage : msw_pkg
`default_nettype wire

// File: rtl/msw_unpack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msw_unpack: first pipeline stage
// Splits the low 2k index bits into x and y codes, keeps the block bits
// above them and checks the index against the texture size.
// ----------------------------------------------------------------------------
module msw_unpack import msw_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [$clog2(MAX_DIM_LOG2+1)-1:0]      wl,
  input  wire logic [$clog2(MAX_DIM_LOG2+1)-1:0]      hl,
  input  wire logic                                   up_valid,
  output logic                                        up_ready,
  input  wire in_t                                    up_data,
  output logic                                        dn_valid,
  input  wire logic                                   dn_ready,
  output unpack_t                                     dn_data
);

  localparam int LW = $clog2(MAX_DIM_LOG2 + 1);

  logic [LW-1:0]     k;
  logic [LW:0]       size_log2;
  logic [31:0]       hi_mask;
  logic [HALF_W-1:0] kmask;
  logic              valid_r;
  unpack_t           data_r;
  unpack_t           data_nxt;

  always_comb begin
    k         = (wl < hl) ? wl : hl;
    size_log2 = {1'b0, wl} + {1'b0, hl};
    hi_mask   = 32'hffff_ffff << {k, 1'b0};
    kmask     = ~(HALF_W'({HALF_W{1'b1}} << k));

    data_nxt.hi  = up_data.source_index & hi_mask[IDX_W-1:0];
    data_nxt.xd  = even_bits({2'b0, up_data.source_index}) & kmask;
    data_nxt.yd  = even_bits({3'b0, up_data.source_index[IDX_W-1:1]}) & kmask;
    data_nxt.ok  = (32'(size_log2) >= 32'(IDX_W)) ||
                   ((up_data.source_index >> size_log2) == '0);
    data_nxt.pix = up_data.pixel_data;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : msw_unpack
`default_nettype wire

// File: rtl/msw_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msw_place: second pipeline stage
// Rebuilds the texel position along the longer side, splits it into x and
// y and forms the row-major texel position y*W + x.
// ----------------------------------------------------------------------------
module msw_place import msw_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic [$clog2(MAX_DIM_LOG2+1)-1:0]      wl,
  input  wire logic [$clog2(MAX_DIM_LOG2+1)-1:0]      hl,
  input  wire logic                                   up_valid,
  output logic                                        up_ready,
  input  wire unpack_t                                up_data,
  output logic                                        dn_valid,
  input  wire logic                                   dn_ready,
  output place_t                                      dn_data
);

  localparam int LW = $clog2(MAX_DIM_LOG2 + 1);

  logic [LW-1:0]    k;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] x;
  logic [IDX_W-1:0] y;
  logic             valid_r;
  place_t           data_r;
  place_t           data_nxt;

  always_comb begin
    k = (wl < hl) ? wl : hl;
    if (hl < wl) begin
      // wide texture: x runs over blocks, y stays inside one block
      j = up_data.hi | (IDX_W'(up_data.yd) << k) | IDX_W'(up_data.xd);
      x = j >> hl;
      y = j & ~({IDX_W{1'b1}} << hl);
    end else begin
      j = up_data.hi | (IDX_W'(up_data.xd) << k) | IDX_W'(up_data.yd);
      x = j & ~({IDX_W{1'b1}} << wl);
      y = j >> wl;
    end
    data_nxt.pos = (OFF_W'(y) << wl) + OFF_W'(x);
    data_nxt.ok  = up_data.ok;
    data_nxt.pix = up_data.pix;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : msw_place
`default_nettype wire

// File: rtl/msw_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msw_scale: third pipeline stage and output register
// Scales the texel position by the pixel size and zeroes the offset of an
// index outside the texture.
// ----------------------------------------------------------------------------
module msw_scale import msw_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [CFG_W-1:0] bpp,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire place_t           up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output out_t                  dn_data
);

  logic valid_r;
  out_t data_r;
  out_t data_nxt;

  always_comb begin
    data_nxt.dest_byte_offset = up_data.ok ? (up_data.pos * OFF_W'(bpp)) : '0;
    data_nxt.pixel_out        = up_data.pix;
    data_nxt.in_range         = up_data.ok;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule : msw_scale
`default_nettype wire

// File: rtl/morton_swizzle_to_linear_address.sv
`default_nettype none
// ----------------------------------------------------------------------------
// morton_swizzle_to_linear_address: Morton texel index to linear byte offset
// Turns the index of a texel in a Morton-ordered texture into its byte
// offset in the row-major texture and carries the pixel alongside.
// ----------------------------------------------------------------------------
//
//   port group   direction  transaction            flow control
//   in_*         in         source index + pixel   in_valid / in_stall
//   out_*        out        offset, pixel, range   out_valid / out_stall
//   cfg_*        in         register write         cfg_we, no wait
//
// Three register stages: axis split, placement, scale. A transaction passes
// through them in order and one is taken every cycle while in_stall is low;
// the output register of the scale stage holds the result.
// A stall on the output holds the full stages; an empty stage still takes
// the next transaction, so bubbles close up.
// Synchronous reset empties the pipeline and loads the register defaults
// (width and height log2 of 0, four bytes per pixel).
// Write configuration only while the pipeline is empty.
// ----------------------------------------------------------------------------
module morton_swizzle_to_linear_address import msw_pkg::*; #(
  parameter int MAX_DIM_LOG2 = MAX_DIM_LOG2_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]      cfg_wdata
);

  localparam int LW = $clog2(MAX_DIM_LOG2 + 1);
  localparam logic [CFG_W-1:0] DIM_LIMIT = CFG_W'(MAX_DIM_LOG2);

  logic [CFG_W-1:0] width_log2_r;
  logic [CFG_W-1:0] height_log2_r;
  logic [CFG_W-1:0] bpp_r;
  logic [LW-1:0]    wl;
  logic [LW-1:0]    hl;
  logic [CFG_W-1:0] bpp;

  logic    s1_ready;
  logic    s1_valid;
  unpack_t s1_data;
  logic    s2_ready;
  logic    s2_valid;
  place_t  s2_data;
  logic    s3_ready;

  // Configuration registers; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_log2_r  <= '0;
      height_log2_r <= '0;
      bpp_r         <= BPP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_WIDTH_LOG2:  width_log2_r  <= cfg_wdata;
        REG_HEIGHT_LOG2: height_log2_r <= cfg_wdata;
        REG_PIXEL_BYTES: bpp_r         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturate the side lengths to the supported limit and clamp the pixel
  // size into one to eight bytes.
  always_comb begin
    wl  = (width_log2_r  > DIM_LIMIT) ? LW'(DIM_LIMIT) : LW'(width_log2_r);
    hl  = (height_log2_r > DIM_LIMIT) ? LW'(DIM_LIMIT) : LW'(height_log2_r);
    bpp = (bpp_r == '0) ? BPP_MIN : ((bpp_r > BPP_MAX) ? BPP_MAX : bpp_r);
  end

  // Stage 1: split the Morton code, range check
  msw_unpack #(
    .MAX_DIM_LOG2(MAX_DIM_LOG2)
  ) u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .wl       (wl),
    .hl       (hl),
    .up_valid (in_valid),
    .up_ready (s1_ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s2_ready),
    .dn_data  (s1_data)
  );

  // Stage 2: row-major texel position
  msw_place #(
    .MAX_DIM_LOG2(MAX_DIM_LOG2)
  ) u_place (
    .clk      (clk),
    .rst_n    (rst_n),
    .wl       (wl),
    .hl       (hl),
    .up_valid (s1_valid),
    .up_ready (s2_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s3_ready),
    .dn_data  (s2_data)
  );

  // Stage 3: scale to bytes, output register
  msw_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .bpp      (bpp),
    .up_valid (s2_valid),
    .up_ready (s3_ready),
    .up_data  (s2_data),
    .dn_valid (out_valid),
    .dn_ready (!out_stall),
    .dn_data  (out_data)
  );

  assign in_stall = !s1_ready;

endmodule : morton_swizzle_to_linear_address
`default_nettype wire
